// ===== rtl/amdfs_pkg.sv =====
`timescale 1ns / 1ps

package amdfs_pkg;

   localparam int OPC_W   = 2;
   localparam int NODE_W  = 6;
   localparam int LABEL_W = 8;
   localparam int CNT_W   = 7;

   localparam int MAX_NODES_DEF = 64;
   localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;

   localparam logic [OPC_W-1:0] OP_SET_LABEL = 2'd0;
   localparam logic [OPC_W-1:0] OP_ADD_EDGE  = 2'd1;
   localparam logic [OPC_W-1:0] OP_WALK      = 2'd2;

   // source of the adjacency row read address
   localparam logic [1:0] ROW_SRC_REQ = 2'd0;
   localparam logic [1:0] ROW_SRC_TOP = 2'd1;
   localparam logic [1:0] ROW_SRC_STK = 2'd2;

   typedef struct packed {
      logic [OPC_W-1:0]   opcode;
      logic [NODE_W-1:0]  node_a;
      logic [NODE_W-1:0]  node_b;
      logic [LABEL_W-1:0] label;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0]  node_index;
      logic [LABEL_W-1:0] node_label;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic       take;
      logic       lab_wr;
      logic       start;
      logic       edge_wr;
      logic       push;
      logic       pop;
      logic       top_load;
      logic       emit;
      logic       emit_last;
      logic [1:0] row_src;
   } cmd_type;

   typedef struct packed {
      logic [OPC_W-1:0] opcode;
      logic             label_ok;
      logic             edge_ok;
      logic             start_ok;
      logic             cand_nz;
      logic             depth_one;
      logic             out_free;
   } stat_type;

endpackage

// ===== rtl/adjacency_matrix_dfs_unit.sv =====
// Directed graph walker: adjacency bit matrix plus one label byte per node.
// req_ channel (valid/ready) carries commands: set label, add edge, start walk.
// rsp_ channel (valid/ready) carries one transfer per visited node, in
// depth-first order (lowest neighbor first), with last set on the final one.
// csr_wr_en/csr_wr_data write node_count; write it only while no walk runs.
// Set label writes the label as the command is taken; add edge reads the
// row, then writes it back. In a walk, a push costs a row fetch and an
// evaluate, a pop costs an evaluate and a stack read; the first result is
// loaded in the evaluate step, or in the finish step when the start node
// has no neighbor.
// req_ready is high only between commands; one command is worked at a time.
// If the receiver stalls, the result register holds and the walk waits in
// its evaluate or finish step; nothing is dropped.
// Reset clears per-row valid bits so the matrix reads empty at once (no
// clearing pass), clears visited marks and stack depth, and sets
// node_count to 64.
`timescale 1ns / 1ps

module adjacency_matrix_dfs_unit import amdfs_pkg::*; #(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_payload,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data
);

   // node_count register
   logic [CNT_W-1:0] node_count_ff, node_count_in;

   cmd_type  cmd;
   stat_type stat;

   assign node_count_in = csr_wr_en ? csr_wr_data : node_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RST;
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   // sequencer: decodes commands, steps the walk
   amdfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // matrix, labels, stack, visited marks, result register
   amdfs_dpath #(
      .MAX_NODES (MAX_NODES)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .node_count  (node_count_ff),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // a result is loaded only into a free result register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("result loaded over an untaken transfer");

   // push and pop never in the same step
   a_push_pop: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push && cmd.pop))
      else $error("stack push and pop together");

   // an accepted in-range edge blocks the next command for the write-back
   a_edge_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_payload.opcode == OP_ADD_EDGE && stat.edge_ok)
      |=> !req_ready)
      else $error("command taken during edge write-back");

   // while a non-final result waits, the walk is still running
   a_walk_open: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.last) |-> !req_ready)
      else $error("walk ended without a last result");

endmodule

// ===== rtl/amdfs_ctrl.sv =====
`timescale 1ns / 1ps

module amdfs_ctrl import amdfs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_EDGE_WR = 3'd1;
   localparam logic [2:0] S_FETCH   = 3'd2;
   localparam logic [2:0] S_EVAL    = 3'd3;
   localparam logic [2:0] S_POP     = 3'd4;
   localparam logic [2:0] S_FINISH  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd         = '0;
      cmd.row_src = ROW_SRC_TOP;
      state_in    = state_ff;
      req_ready   = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            cmd.row_src = ROW_SRC_REQ;
            if (req_valid) begin
               cmd.take = 1'b1;
               unique case (stat.opcode)
                  OP_SET_LABEL: cmd.lab_wr = stat.label_ok;
                  OP_ADD_EDGE: begin
                     if (stat.edge_ok) state_in = S_EDGE_WR;
                  end
                  OP_WALK: begin
                     if (stat.start_ok) begin
                        cmd.start = 1'b1;
                        state_in  = S_FETCH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_EDGE_WR: begin
            cmd.edge_wr = 1'b1;
            state_in    = S_IDLE;
         end
         S_FETCH: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (stat.cand_nz) begin
               if (stat.out_free) begin
                  cmd.push = 1'b1;
                  cmd.emit = 1'b1;
                  state_in = S_FETCH;
               end
            end else begin
               cmd.pop  = 1'b1;
               state_in = stat.depth_one ? S_FINISH : S_POP;
            end
         end
         S_POP: begin
            cmd.row_src  = ROW_SRC_STK;
            cmd.top_load = 1'b1;
            state_in     = S_EVAL;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/amdfs_dpath.sv =====
`timescale 1ns / 1ps

module amdfs_dpath import amdfs_pkg::*; #(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  req_type          req_payload,
   input  logic [CNT_W-1:0] node_count,
   input  cmd_type          cmd,
   output stat_type         stat,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_payload
);

   localparam int IDX_W = $clog2(MAX_NODES);

   function automatic logic [IDX_W-1:0] first_set(input logic [MAX_NODES-1:0] v);
      logic [IDX_W-1:0] r;
      r = '0;
      for (int i = MAX_NODES - 1; i >= 0; i--) begin
         if (v[i]) r = IDX_W'(i);
      end
      return r;
   endfunction

   function automatic logic [MAX_NODES-1:0] one_hot(input logic [IDX_W-1:0] i);
      return MAX_NODES'(1) << i;
   endfunction

   // memories
   logic [MAX_NODES-1:0] adj_mem   [MAX_NODES];
   logic [LABEL_W-1:0]   label_mem [MAX_NODES];
   logic [IDX_W-1:0]     stack_mem [MAX_NODES];

   // control registers
   logic [MAX_NODES-1:0] row_vld_ff, row_vld_in;
   logic [MAX_NODES-1:0] visited_ff, visited_in;
   logic [CNT_W-1:0]     depth_ff, depth_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [MAX_NODES-1:0] row_rd_ff;
   logic                 row_ok_ff;
   logic [IDX_W-1:0]     stk_rd_ff;
   logic [LABEL_W-1:0]   lab_rd_ff;
   logic [IDX_W-1:0]     lat_a_ff, lat_a_in;
   logic [IDX_W-1:0]     lat_b_ff, lat_b_in;
   logic [IDX_W-1:0]     top_ff, top_in;
   logic [IDX_W-1:0]     held_ff, held_in;
   rsp_type              rsp_ff, rsp_in;

   logic [CNT_W-1:0]     n_act;
   logic [MAX_NODES-1:0] act_mask;
   logic [MAX_NODES-1:0] cand;
   logic [MAX_NODES-1:0] edge_row;
   logic [IDX_W-1:0]     next_idx;
   logic [IDX_W-1:0]     req_a_idx;
   logic [IDX_W-1:0]     row_raddr;
   logic [CNT_W-1:0]     stk_rd_pos;
   logic                 can_push;
   logic                 out_free;

   // clamp node_count into 1..MAX_NODES
   always_comb begin
      if (node_count == '0) begin
         n_act = CNT_W'(1);
      end else if (node_count > CNT_W'(MAX_NODES)) begin
         n_act = CNT_W'(MAX_NODES);
      end else begin
         n_act = node_count;
      end
      for (int i = 0; i < MAX_NODES; i++) begin
         act_mask[i] = (CNT_W'(i) < n_act);
      end
   end

   assign req_a_idx = req_payload.node_a[IDX_W-1:0];
   assign cand      = row_ok_ff ? (row_rd_ff & act_mask & ~visited_ff) : '0;
   assign next_idx  = first_set(cand);
   assign edge_row  = (row_ok_ff ? row_rd_ff : '0) | one_hot(lat_b_ff);
   assign can_push  = cmd.push && (depth_ff < CNT_W'(MAX_NODES));
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign stk_rd_pos = depth_ff - CNT_W'(2);

   always_comb begin
      unique case (cmd.row_src)
         ROW_SRC_REQ: row_raddr = req_a_idx;
         ROW_SRC_TOP: row_raddr = top_ff;
         ROW_SRC_STK: row_raddr = stk_rd_ff;
         default:     row_raddr = top_ff;
      endcase
   end

   always_comb begin
      stat.opcode    = req_payload.opcode;
      stat.label_ok  = {1'b0, req_payload.node_a} < CNT_W'(MAX_NODES);
      stat.start_ok  = {1'b0, req_payload.node_a} < n_act;
      stat.edge_ok   = stat.start_ok && ({1'b0, req_payload.node_b} < n_act);
      stat.cand_nz   = |cand;
      stat.depth_one = (depth_ff == CNT_W'(1));
      stat.out_free  = out_free;
   end

   always_comb begin
      row_vld_in   = row_vld_ff;
      visited_in   = visited_ff;
      depth_in     = depth_ff;
      rsp_valid_in = rsp_valid_ff;
      lat_a_in     = lat_a_ff;
      lat_b_in     = lat_b_ff;
      top_in       = top_ff;
      held_in      = held_ff;
      rsp_in       = rsp_ff;
      if (cmd.take) begin
         lat_a_in = req_a_idx;
         lat_b_in = req_payload.node_b[IDX_W-1:0];
      end
      if (cmd.edge_wr) row_vld_in[lat_a_ff] = 1'b1;
      priority if (cmd.start) begin
         visited_in = one_hot(req_a_idx);
         depth_in   = CNT_W'(1);
         top_in     = req_a_idx;
         held_in    = req_a_idx;
      end else if (cmd.push) begin
         visited_in = visited_ff | one_hot(next_idx);
         if (can_push) depth_in = depth_ff + CNT_W'(1);
         top_in     = next_idx;
         held_in    = next_idx;
      end else if (cmd.pop) begin
         depth_in = depth_ff - CNT_W'(1);
      end else if (cmd.top_load) begin
         top_in = stk_rd_ff;
      end else begin
      end
      if (cmd.emit) begin
         rsp_valid_in      = 1'b1;
         rsp_in.node_index = NODE_W'(held_ff);
         rsp_in.node_label = lab_rd_ff;
         rsp_in.last       = cmd.emit_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff   <= '0;
         visited_ff   <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_vld_ff   <= row_vld_in;
         visited_ff   <= visited_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lat_a_ff <= lat_a_in;
      lat_b_ff <= lat_b_in;
      top_ff   <= top_in;
      held_ff  <= held_in;
      rsp_ff   <= rsp_in;
   end

   // adjacency rows: read every cycle, written on edge insert
   always_ff @(posedge clock) begin
      row_rd_ff <= adj_mem[row_raddr];
      row_ok_ff <= row_vld_ff[row_raddr];
      if (cmd.edge_wr) adj_mem[lat_a_ff] <= edge_row;
   end

   // labels: read port follows the held node
   always_ff @(posedge clock) begin
      lab_rd_ff <= label_mem[held_ff];
      if (cmd.lab_wr) label_mem[req_a_idx] <= req_payload.label;
   end

   // walk stack: read port sits one below the top
   always_ff @(posedge clock) begin
      stk_rd_ff <= stack_mem[stk_rd_pos[IDX_W-1:0]];
      if (cmd.start) begin
         stack_mem[0] <= req_a_idx;
      end else if (can_push) begin
         stack_mem[depth_ff[IDX_W-1:0]] <= next_idx;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== bench/tb_adjacency_matrix_dfs_unit.sv =====
`timescale 1ns / 1ps

// Sender pushes commands in bursts; receiver stalls on its own pattern.
// Every result transfer is checked, field by field, against a local graph
// walker (tracking the same edge rows, labels and node count) or typed in.
module tb_adjacency_matrix_dfs_unit;
   import amdfs_pkg::*;

   // opcode 3 has no meaning; the block must drop it without a result
   localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

   localparam int GRAPH_NODES   = MAX_NODES_DEF;
   localparam int ITEM_GOAL     = 330;  // label writes, table rows and random commands in all
   localparam int HOLD_CYCLES   = 400;  // long receiver hold-off
   localparam int SETTLE_CYCLES = 8;    // margin for a trailing add edge write-back

   typedef enum {RX_OPEN, RX_COIN, RX_EVERY4, RX_MOSTLY} rx_mode_type;

   // one line of the directed table: a command, or a node_count write
   typedef struct {
      bit               cfg_row;
      logic [CNT_W-1:0] cfg_val;
      req_type          cmd;
      int               n_typed;  // results typed in below; -1 leaves it to the walker
      rsp_type          typed;
   } step_row_type;

   logic             clock;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   req_type          req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   rsp_type          rsp_payload;
   logic             csr_wr_en   = 1'b0;
   logic [CNT_W-1:0] csr_wr_data = '0;

   // travels with the payload so the accept side knows how to predict it
   int      offer_typed_n = -1;
   rsp_type offer_typed   = '0;

   // local copy of the graph and of node_count
   logic [GRAPH_NODES-1:0] edge_bits [GRAPH_NODES] = '{default: '0};
   logic [LABEL_W-1:0]     label_mem [GRAPH_NODES] = '{default: '0};
   logic [CNT_W-1:0]       node_count_m = NODE_COUNT_RST;

   rsp_type expected_visits [$];
   int      errors      = 0;
   int      visits_seen = 0;
   int      burst_left  = 0;

   adjacency_matrix_dfs_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // node_count as the block sees it: zero acts as one, above 64 acts as 64
   function automatic int unsigned active_count();
      if (node_count_m == 0) return 1;
      if (node_count_m > GRAPH_NODES) return GRAPH_NODES;
      return node_count_m;
   endfunction

   // Applies one accepted command to the local graph and queues the visits
   // it should produce. Neighbors are taken lowest index first off the top
   // of an explicit stack, which matches recursive depth-first order.
   function automatic void predict_command(input req_type r, input int n_typed,
                                           input rsp_type typed);
      int unsigned            n;
      int unsigned            depth;
      logic [GRAPH_NODES-1:0] in_use;
      logic [GRAPH_NODES-1:0] open;
      logic [GRAPH_NODES-1:0] seen;
      logic [NODE_W-1:0]      stack [GRAPH_NODES];
      logic [NODE_W-1:0]      nxt;
      rsp_type                held;
      n      = active_count();
      in_use = '1;
      in_use = in_use >> (GRAPH_NODES - n);
      nxt    = '0;
      case (r.opcode)
         OP_SET_LABEL: label_mem[r.node_a] = r.label;
         OP_ADD_EDGE: begin
            // edges touching a node outside the count are dropped
            if (r.node_a < n && r.node_b < n) edge_bits[r.node_a][r.node_b] = 1'b1;
         end
         OP_WALK: begin
            if (r.node_a < n && n_typed < 0) begin
               seen           = '0;
               seen[r.node_a] = 1'b1;
               stack[0]       = r.node_a;
               depth          = 1;
               held = '{node_index: r.node_a, node_label: label_mem[r.node_a], last: 1'b0};
               while (depth != 0) begin
                  // stored edges beyond the current count are masked off here
                  open = edge_bits[stack[depth - 1]] & in_use & ~seen;
                  if (open == '0) begin
                     depth--;
                  end else begin
                     for (int i = GRAPH_NODES - 1; i >= 0; i--) begin
                        if (open[i]) nxt = NODE_W'(i);
                     end
                     seen[nxt]    = 1'b1;
                     stack[depth] = nxt;
                     depth++;
                     // hold one visit back so the final one can carry last
                     expected_visits.push_back(held);
                     held = '{node_index: nxt, node_label: label_mem[nxt], last: 1'b0};
                  end
               end
               held.last = 1'b1;
               expected_visits.push_back(held);
            end
         end
         default: ;
      endcase
      for (int k = 0; k < n_typed; k++) expected_visits.push_back(typed);
   endfunction

   function automatic step_row_type cmd_step(input logic [OPC_W-1:0] op, input int a,
                                             input int b, input int lab,
                                             input int n_typed = -1,
                                             input int idx = 0, input int lbl = 0);
      step_row_type s;
      s.cfg_row = 1'b0;
      s.cfg_val = '0;
      s.cmd     = '{opcode: op, node_a: NODE_W'(a), node_b: NODE_W'(b), label: LABEL_W'(lab)};
      s.n_typed = n_typed;
      s.typed   = '{node_index: NODE_W'(idx), node_label: LABEL_W'(lbl), last: 1'b1};
      return s;
   endfunction

   function automatic step_row_type cfg_step(input int v);
      step_row_type s;
      s         = cmd_step(OP_UNUSED, 0, 0, 0);
      s.cfg_row = 1'b1;
      s.cfg_val = CNT_W'(v);
      return s;
   endfunction

   // Random command for a graph of n nodes. Mostly in-range edges, chain
   // links and walks; the rest are stray edges, label writes and opcode 3.
   function automatic req_type random_command(input int unsigned n);
      req_type     r;
      int unsigned a;
      int unsigned pick;
      r.opcode = OP_ADD_EDGE;
      r.node_a = NODE_W'($urandom);
      r.node_b = NODE_W'($urandom);
      r.label  = LABEL_W'($urandom);
      a        = $urandom_range(0, n - 1);
      pick     = $urandom_range(0, 99);
      if (pick < 34) begin
         r.node_a = NODE_W'(a);
         r.node_b = NODE_W'($urandom_range(0, n - 1));
      end else if (pick < 50) begin
         // chain links build long paths, so stacks get deep
         r.node_a = NODE_W'(a);
         r.node_b = NODE_W'((a + 1) % n);
      end else if (pick < 58) begin
         // any pair; often outside the count
      end else if (pick < 65) begin
         r.opcode = OP_SET_LABEL;
      end else if (pick < 90) begin
         r.opcode = OP_WALK;
         r.node_a = NODE_W'(a);
      end else if (pick < 95) begin
         r.opcode = OP_WALK;
      end else begin
         r.opcode = OP_UNUSED;
      end
      return r;
   endfunction

   // Offers one command and waits for its transfer. Bursts of random length
   // with random gaps; a gap of zero keeps valid high straight through.
   // req_ready follows the block's state only, so its value at the falling
   // edge is the one the next rising edge takes.
   task automatic offer(input req_type r, input int n_typed, input rsp_type typed);
      int unsigned gap;
      bit          taken;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 6);
         gap        = $urandom_range(0, 5);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_payload   <= r;
      offer_typed_n <= n_typed;
      offer_typed   <= typed;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end
   endtask

   // Stop sending, let every queued visit arrive, then wait out the settle
   // margin so a trailing label or edge write can finish.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_visits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_node_count(input logic [CNT_W-1:0] v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      node_count_m  = v;
   endtask

   // Sampled at the falling edge, where the handshakes hold what the next
   // rising edge takes. Result check first, then prediction; a walk's
   // results never share an edge with its own start transfer.
   always @(negedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            visits_seen <= visits_seen + 1;
            if (expected_visits.size() == 0) begin
               $error("unexpected visit: node_index %0d node_label %0h last %0b",
                      rsp_payload.node_index, rsp_payload.node_label, rsp_payload.last);
               errors++;
            end else begin
               want = expected_visits.pop_front();
               if (rsp_payload.node_index !== want.node_index) begin
                  $error("node_index: expected %0d, got %0d",
                         want.node_index, rsp_payload.node_index);
                  errors++;
               end
               if (rsp_payload.node_label !== want.node_label) begin
                  $error("node_label: expected %0h, got %0h",
                         want.node_label, rsp_payload.node_label);
                  errors++;
               end
               if (rsp_payload.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_payload.last);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) predict_command(req_payload, offer_typed_n, offer_typed);
      end
   end

   // Receiver: changes stall pattern every so often, including long open
   // stretches. Once, after 40 visits, it holds off long enough that the
   // result register fills and req_ready drops while commands are still offered.
   initial begin : rsp_side
      rx_mode_type mode     = RX_OPEN;
      int unsigned span     = 0;
      int unsigned beat     = 0;
      bit          held_off = 1'b0;
      forever begin
         @(posedge clock);
         if (!held_off && visits_seen >= 40) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (span == 0) begin
            mode = rx_mode_type'($urandom_range(0, 3));
            span = $urandom_range(20, 200);
         end
         span--;
         beat++;
         case (mode)
            RX_OPEN:   rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            RX_EVERY4: rsp_ready <= (beat % 4 == 0);
            default:   rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   initial begin : stimulus
      step_row_type plan [$];
      req_type      r;
      int unsigned  n;
      int unsigned  counted;
      int unsigned  phase_items;
      int           phase;

      // directed table; single-visit and empty walks typed in directly
      plan.push_back(cmd_step(OP_SET_LABEL, 0, 0, 8'h00));
      plan.push_back(cmd_step(OP_SET_LABEL, 63, 63, 8'hFF));
      plan.push_back(cmd_step(OP_WALK, 0, 0, 0, 1, 0, 8'h00));     // matrix empty after reset
      plan.push_back(cmd_step(OP_WALK, 63, 0, 0, 1, 63, 8'hFF));
      plan.push_back(cmd_step(OP_ADD_EDGE, 0, 1, 0));
      plan.push_back(cmd_step(OP_ADD_EDGE, 1, 63, 0));
      plan.push_back(cmd_step(OP_ADD_EDGE, 0, 63, 0));
      plan.push_back(cmd_step(OP_ADD_EDGE, 63, 0, 0));             // cycle back to start
      plan.push_back(cmd_step(OP_ADD_EDGE, 5, 5, 0));              // self loop
      plan.push_back(cmd_step(OP_ADD_EDGE, 0, 1, 0));              // repeated edge
      plan.push_back(cmd_step(OP_WALK, 0, 63, 8'hFF));
      plan.push_back(cmd_step(OP_WALK, 5, 0, 0));
      plan.push_back(cmd_step(OP_UNUSED, 63, 63, 8'hFF, 0));
      plan.push_back(cfg_step(1));
      plan.push_back(cmd_step(OP_WALK, 1, 0, 0, 0));               // start outside count
      plan.push_back(cmd_step(OP_ADD_EDGE, 1, 0, 0));              // dropped, source outside
      plan.push_back(cmd_step(OP_WALK, 0, 0, 0, 1, 0, 8'h00));     // stored edges masked off
      plan.push_back(cfg_step(0));                                 // zero behaves as one
      plan.push_back(cmd_step(OP_WALK, 0, 0, 0, 1, 0, 8'h00));
      plan.push_back(cmd_step(OP_WALK, 63, 0, 0, 0));
      plan.push_back(cmd_step(OP_SET_LABEL, 40, 0, 8'hA5));        // kept though outside count
      plan.push_back(cfg_step(127));                               // clamps to 64
      plan.push_back(cmd_step(OP_WALK, 40, 0, 0, 1, 40, 8'hA5));
      plan.push_back(cmd_step(OP_WALK, 63, 0, 0));
      plan.push_back(cfg_step(64));
      plan.push_back(cmd_step(OP_ADD_EDGE, 63, 62, 0));
      plan.push_back(cmd_step(OP_WALK, 1, 0, 0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // every label gets written before any walk can reach it
      for (int i = 0; i < GRAPH_NODES; i++) begin
         r = '{opcode: OP_SET_LABEL, node_a: NODE_W'(i), node_b: NODE_W'($urandom),
               label: LABEL_W'($urandom)};
         offer(r, -1, '0);
      end

      foreach (plan[k]) begin
         if (plan[k].cfg_row) begin
            write_node_count(plan[k].cfg_val);
         end else begin
            offer(plan[k].cmd, plan[k].n_typed, plan[k].typed);
         end
      end

      // random phases, each under its own node_count; the graph keeps
      // growing across phases since nothing clears it but reset
      counted = GRAPH_NODES + plan.size();
      phase   = 0;
      while (counted < ITEM_GOAL) begin
         case ((phase == 0) ? 0 : $urandom_range(0, 6))
            0, 1:    write_node_count(NODE_COUNT_RST);
            2:       write_node_count(CNT_W'($urandom_range(1, 8)));
            3:       write_node_count(CNT_W'($urandom_range(1, 64)));
            4:       write_node_count(CNT_W'($urandom_range(33, 64)));
            5:       write_node_count(CNT_W'($urandom_range(65, 127)));
            default: write_node_count('0);
         endcase
         phase++;
         phase_items = $urandom_range(15, 40);
         n = active_count();
         for (int j = 0; j < int'(phase_items) && counted < ITEM_GOAL; j++) begin
            r = random_command(n);
            counted++;
            offer(r, -1, '0);
         end
      end

      drain();
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // well past the slowest legal run: every walk full length, every result stalled
   initial begin : watchdog
      #3_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
